[hdl/wppd_pkg.sv]
// Shared types and constants of the windowed peak-to-peak detector.
// Used by the window cells, the top level and the checker; depends on nothing.
package wppd_pkg;

	localparam int SAMPLE_BITS        = 24;
	localparam int MAX_SEPARATION_DEF = 32;
	localparam int CFG_BITS           = 6;
	localparam logic [CFG_BITS-1:0] MIN_SEP_RESET = 6'd4;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          record_end;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] peak_to_peak;
		logic                   is_end_marker;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEL,
		ST_CMP,
		ST_DEC,
		ST_END
	} state_t;

	typedef struct packed {
		logic                          shift;
		logic                          cmp;
		logic                          up;
		logic signed [SAMPLE_BITS-1:0] cur;
	} cell_ctl_t;

endpackage

[hdl/wppd_cell.sv]
// One window cell: holds one sample, shifts to its neighbor on a new request,
// and checks its sample against the broadcast candidate. Depends on wppd_pkg.
module wppd_cell #(
	parameter int IDX = 0,
	parameter int IW  = 6
) (
	input  logic                                   clk,
	input  wppd_pkg::cell_ctl_t                    ctl,
	input  logic signed [wppd_pkg::SAMPLE_BITS-1:0] din,
	input  logic [IW-1:0]                          k,
	input  logic [IW-1:0]                          lo,
	input  logic [IW-1:0]                          hi,
	output logic signed [wppd_pkg::SAMPLE_BITS-1:0] val,
	output logic signed [wppd_pkg::SAMPLE_BITS-1:0] rd_cur,
	output logic signed [wppd_pkg::SAMPLE_BITS-1:0] rd_nxt,
	output logic                                   fail
);

	logic signed [wppd_pkg::SAMPLE_BITS-1:0] val_q;
	logic signed [wppd_pkg::SAMPLE_BITS-1:0] cur_v;
	logic                                    fail_q;
	logic                                    in_range;
	logic                                    sel_cur;
	logic                                    sel_nxt;

	assign cur_v    = ctl.cur;
	assign in_range = (int'(lo) <= IDX) && (int'(hi) >= IDX);
	assign sel_cur  = (int'(k) == IDX);
	assign sel_nxt  = (int'(k) == IDX + 1);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			val_q <= din;
		end
		if (ctl.cmp) begin
			fail_q <= in_range && (ctl.up ? (val_q > cur_v) : (val_q < cur_v));
		end
	end

	assign val    = val_q;
	assign rd_cur = sel_cur ? val_q : '0;
	assign rd_nxt = sel_nxt ? val_q : '0;
	assign fail   = fail_q;

endmodule

[hdl/windowed_peak_to_peak_detector.sv]
// Windowed peak-to-peak detector: chain of 2*MAX_SEPARATION window cells plus judging sequencer.
// Depends on wppd_pkg and wppd_cell.
// Throughput: one sample per cycle while no candidate is due; when one is judged, new samples
// stall through select, compare in all cells and decide, which waits on out_stall; end of record
// flushes each remaining candidate through select, compare and decide, then writes the end marker.
// Reset (arst_n low, async): record state cleared, min_separation = 4; window cells not cleared.
module windowed_peak_to_peak_detector #(
	parameter int MAX_SEPARATION = wppd_pkg::MAX_SEPARATION_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  wppd_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output wppd_pkg::out_item_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wppd_pkg::CFG_BITS-1:0]     cfg_data
);

	localparam int SB    = wppd_pkg::SAMPLE_BITS;
	localparam int DEPTH = 2 * MAX_SEPARATION;
	localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int MW    = $clog2(MAX_SEPARATION + 1);
	localparam int CW    = $clog2(DEPTH + 1);

	wppd_pkg::state_t state_q, state_d;

	logic [CW-1:0]                 seen_q;
	logic [CW-1:0]                 n_q;
	logic                          last_q;
	logic [MW-1:0]                 k_q;
	logic                          up_q;
	logic                          pend_q;
	logic [wppd_pkg::CFG_BITS-1:0] msep_q;
	logic signed [SB-1:0]          held_q;
	logic signed [SB-1:0]          cur_s1;
	logic signed [SB-1:0]          nxt_s1;
	logic [IW-1:0]                 lo_s1;
	logic [IW-1:0]                 hi_s1;
	wppd_pkg::out_item_t           out_q;
	logic                          out_vld_q;

	logic [MW-1:0]        m;
	logic [MW-1:0]        d;
	logic [IW-1:0]        lo_c;
	logic [IW-1:0]        hi_c;
	logic                 accept;
	logic                 out_free;
	logic                 cand;
	logic                 take;
	logic                 emit_pair;
	logic                 dec_done;
	logic                 wr_end;
	logic                 wr;
	logic signed [SB:0]   diff;
	logic [SB:0]          mag;
	logic signed [SB-1:0] cur_bus;
	logic signed [SB-1:0] nxt_bus;

	wppd_pkg::cell_ctl_t  ctl;
	logic signed [SB-1:0] val    [DEPTH];
	logic signed [SB-1:0] rd_cur [DEPTH];
	logic signed [SB-1:0] rd_nxt [DEPTH];
	logic [DEPTH-1:0]     fail;

	assign cfg_ready = 1'b1;

	always_comb begin
		m = (int'(msep_q) > MAX_SEPARATION) ? MW'(MAX_SEPARATION) : MW'(msep_q);
		d = (m > MW'(1)) ? m - MW'(1) : MW'(1);
	end

	// window bounds for candidate k: [max(k+1-m,0), min(k+m,n)]
	always_comb begin
		int kv;
		int mv;
		int nv;
		kv   = int'(k_q);
		mv   = int'(m);
		nv   = int'(n_q);
		hi_c = IW'((kv + mv < nv) ? kv + mv : nv);
		lo_c = IW'((kv + 1 > mv) ? kv + 1 - mv : 0);
	end

	assign ctl.shift = accept;
	assign ctl.cmp   = (state_q == wppd_pkg::ST_CMP);
	assign ctl.up    = up_q;
	assign ctl.cur   = cur_s1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		wppd_cell #(
			.IDX (i),
			.IW  (IW)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.din    ((i == 0) ? in_data.sample : val[(i == 0) ? 0 : i - 1]),
			.k      (IW'(k_q)),
			.lo     (lo_s1),
			.hi     (hi_s1),
			.val    (val[i]),
			.rd_cur (rd_cur[i]),
			.rd_nxt (rd_nxt[i]),
			.fail   (fail[i])
		);
	end

	always_comb begin
		cur_bus = '0;
		nxt_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			cur_bus = cur_bus | rd_cur[i];
			nxt_bus = nxt_bus | rd_nxt[i];
		end
	end

	always_comb begin
		cand      = up_q ? (nxt_s1 < cur_s1) : (nxt_s1 > cur_s1);
		take      = cand && !(|fail);
		emit_pair = take && pend_q;
		diff      = {held_q[SB-1], held_q} - {cur_s1[SB-1], cur_s1};
		mag       = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
	end

	assign in_stall = (state_q != wppd_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_vld_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		dec_done = 1'b0;
		wr_end   = 1'b0;
		case (state_q)
			wppd_pkg::ST_IDLE: begin
				if (accept) begin
					if (seen_q >= CW'(d)) begin
						state_d = wppd_pkg::ST_SEL;
					end else if (in_data.record_end && seen_q != '0) begin
						state_d = wppd_pkg::ST_SEL;
					end else if (in_data.record_end) begin
						state_d = wppd_pkg::ST_END;
					end
				end
			end
			wppd_pkg::ST_SEL: state_d = wppd_pkg::ST_CMP;
			wppd_pkg::ST_CMP: state_d = wppd_pkg::ST_DEC;
			wppd_pkg::ST_DEC: begin
				if (!emit_pair || out_free) begin
					dec_done = 1'b1;
					if (last_q && k_q > MW'(1)) begin
						state_d = wppd_pkg::ST_SEL;
					end else if (last_q) begin
						state_d = wppd_pkg::ST_END;
					end else begin
						state_d = wppd_pkg::ST_IDLE;
					end
				end
			end
			wppd_pkg::ST_END: begin
				if (out_free) begin
					wr_end  = 1'b1;
					state_d = wppd_pkg::ST_IDLE;
				end
			end
			default: state_d = wppd_pkg::ST_IDLE;
		endcase
	end

	assign wr = (dec_done && emit_pair) || wr_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= wppd_pkg::ST_IDLE;
			seen_q    <= '0;
			n_q       <= '0;
			last_q    <= 1'b0;
			k_q       <= '0;
			up_q      <= 1'b0;
			pend_q    <= 1'b0;
			msep_q    <= wppd_pkg::MIN_SEP_RESET;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				msep_q <= cfg_data;
			end
			if (accept) begin
				n_q    <= seen_q;
				last_q <= in_data.record_end;
				k_q    <= (seen_q >= CW'(d)) ? d : MW'(seen_q);
				if (seen_q == CW'(1)) begin
					up_q <= in_data.sample > val[0];
				end
				if (in_data.record_end) begin
					seen_q <= '0;
				end else if (seen_q < CW'(DEPTH)) begin
					seen_q <= seen_q + CW'(1);
				end
			end
			if (dec_done) begin
				k_q <= k_q - MW'(1);
				if (take) begin
					up_q   <= !up_q;
					pend_q <= !pend_q;
				end
			end
			if (wr_end) begin
				up_q   <= 1'b0;
				pend_q <= 1'b0;
			end
			if (wr) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wppd_pkg::ST_SEL) begin
			cur_s1 <= cur_bus;
			nxt_s1 <= nxt_bus;
			lo_s1  <= lo_c;
			hi_s1  <= hi_c;
		end
		if (dec_done && take && !pend_q) begin
			held_q <= cur_s1;
		end
		if (wr_end) begin
			out_q.peak_to_peak  <= '0;
			out_q.is_end_marker <= 1'b1;
		end else if (dec_done && emit_pair) begin
			out_q.peak_to_peak  <= mag[SB-1:0];
			out_q.is_end_marker <= 1'b0;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

[hdl/wppd_checker.sv]
// Port-level checker for the windowed peak-to-peak detector, bound to the top level.
// Depends on wppd_pkg and windowed_peak_to_peak_detector.
module wppd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input wppd_pkg::in_item_t            in_data,
	input logic                          out_valid,
	input logic                          out_stall,
	input wppd_pkg::out_item_t           out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.record_end |=> in_stall)
		else $error("not busy after last sample of record");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.is_end_marker |-> out_data.peak_to_peak == '0)
		else $error("end marker carries nonzero value");

	a_new_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule

bind windowed_peak_to_peak_detector wppd_checker u_wppd_checker (.*);
